### sv/list_union_merge_assert.svh
// Assertion macros shared by the list union merge RTL
`ifndef LIST_UNION_MERGE_ASSERT_SVH
`define LIST_UNION_MERGE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset
`define LUM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define LUM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lum_pkg.sv
// Types, codes and microprogram ROM for the list union merge block
package lum_pkg;

   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND_FIRST  = 2'd0,
      OP_APPEND_SECOND = 2'd1,
      OP_MERGE         = 2'd2,
      OP_UNUSED        = 2'd3
   } op_type;

   // microprogram addresses
   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_CP_RD,
      S_CP_WR,
      S_SRC_CHK,
      S_SRC_RD,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_APPEND,
      S_NEXT,
      S_OUT_RD,
      S_OUT_HOLD,
      S_OUT_NEXT,
      S_EMPTY,
      S_DONE
   } step_type;

   // branch conditions
   typedef enum logic [3:0] {
      C_ALWAYS,
      C_MERGE,
      C_BOTH_EMPTY,
      C_CP_END,
      C_J_END,
      C_K_END,
      C_MATCH,
      C_RSP_ACC,
      C_OUT_END
   } cond_type;

   typedef enum logic [1:0] {
      IX_HOLD,
      IX_ZERO,
      IX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      MX_HOLD,
      MX_LOAD,
      MX_INC
   } m_op_type;

   typedef enum logic [1:0] {
      MRD_NONE,
      MRD_K,
      MRD_I
   } mrd_type;

   typedef enum logic [1:0] {
      MWR_NONE,
      MWR_COPY,
      MWR_APPEND
   } mwr_type;

   typedef struct packed {
      cond_type   cond;
      step_type   next_t;
      step_type   next_f;
      idx_op_type i_op;
      idx_op_type j_op;
      idx_op_type k_op;
      m_op_type   m_op;
      logic       pick_src;
      logic       list_rd;
      logic       list_rd_src;
      mrd_type    mrd;
      mwr_type    mwr;
      logic       in_ready;
      logic       out_valid;
      logic       out_empty;
      logic       clr_counts;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(input step_type step);
      ucode_word_type w;
      w             = '0;
      w.cond        = C_ALWAYS;
      w.next_t      = S_IDLE;
      w.next_f      = S_IDLE;
      w.i_op        = IX_HOLD;
      w.j_op        = IX_HOLD;
      w.k_op        = IX_HOLD;
      w.m_op        = MX_HOLD;
      w.mrd         = MRD_NONE;
      w.mwr         = MWR_NONE;
      case (step)
         S_IDLE: begin
            w.cond     = C_MERGE;
            w.next_t   = S_SETUP;
            w.next_f   = S_IDLE;
            w.in_ready = 1'b1;
         end
         S_SETUP: begin
            w.cond     = C_BOTH_EMPTY;
            w.next_t   = S_EMPTY;
            w.next_f   = S_CP_RD;
            w.i_op     = IX_ZERO;
            w.j_op     = IX_ZERO;
            w.m_op     = MX_LOAD;
            w.pick_src = 1'b1;
         end
         S_CP_RD: begin
            w.next_t  = S_CP_WR;
            w.list_rd = 1'b1;
         end
         S_CP_WR: begin
            w.cond   = C_CP_END;
            w.next_t = S_SRC_CHK;
            w.next_f = S_CP_RD;
            w.mwr    = MWR_COPY;
            w.i_op   = IX_INC;
         end
         S_SRC_CHK: begin
            w.cond   = C_J_END;
            w.next_t = S_OUT_RD;
            w.next_f = S_SRC_RD;
            w.i_op   = IX_ZERO;
         end
         S_SRC_RD: begin
            w.next_t      = S_SRCH_RD;
            w.list_rd     = 1'b1;
            w.list_rd_src = 1'b1;
            w.k_op        = IX_ZERO;
         end
         S_SRCH_RD: begin
            w.cond   = C_K_END;
            w.next_t = S_APPEND;
            w.next_f = S_SRCH_CMP;
            w.mrd    = MRD_K;
         end
         S_SRCH_CMP: begin
            w.cond   = C_MATCH;
            w.next_t = S_NEXT;
            w.next_f = S_SRCH_RD;
            w.k_op   = IX_INC;
         end
         S_APPEND: begin
            w.next_t = S_NEXT;
            w.mwr    = MWR_APPEND;
            w.m_op   = MX_INC;
         end
         S_NEXT: begin
            w.next_t = S_SRC_CHK;
            w.j_op   = IX_INC;
         end
         S_OUT_RD: begin
            w.next_t = S_OUT_HOLD;
            w.mrd    = MRD_I;
         end
         S_OUT_HOLD: begin
            w.cond      = C_RSP_ACC;
            w.next_t    = S_OUT_NEXT;
            w.next_f    = S_OUT_HOLD;
            w.out_valid = 1'b1;
         end
         S_OUT_NEXT: begin
            w.cond   = C_OUT_END;
            w.next_t = S_DONE;
            w.next_f = S_OUT_RD;
            w.i_op   = IX_INC;
         end
         S_EMPTY: begin
            w.cond      = C_RSP_ACC;
            w.next_t    = S_DONE;
            w.next_f    = S_EMPTY;
            w.out_valid = 1'b1;
            w.out_empty = 1'b1;
         end
         S_DONE: begin
            w.next_t     = S_IDLE;
            w.clr_counts = 1'b1;
         end
         default: begin
            w.next_t = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### sv/list_union_merge.sv
// List union merge: two bounded lists, union by linear search, streamed out
// Appends (operation 0 or 1) are accepted while idle and are dropped when the list
// is full; operation 3 is accepted and ignored. A merge takes the shorter list
// (the first on a tie) as source and the other as destination, copies the
// destination into the merged-list memory, then for every source element
// scans the merged list and appends the value if it is not found. Each step
// is one word of a microprogram ROM driving a datapath with one read port on
// each memory, so each memory read is split into an address step and a
// registered-data step. The scan of the merged list bounds the merge rate.
// Input is stalled from the merge word until the last result word is taken
// and the lists are cleared. Two empty lists give a single word with last and
// empty_res set.
module list_union_merge #(
   parameter int LIST_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lum_pkg::OP_W-1:0]            req_operation,
   input  logic signed [lum_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lum_pkg::VALUE_W-1:0]  rsp_element,
   output logic                                rsp_last,
   output logic                                rsp_empty_res
);
   import lum_pkg::*;

   `include "list_union_merge_assert.svh"

   localparam int MERGED_DEPTH = 2 * LIST_DEPTH;
   localparam int IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int MIDX_W = $clog2(MERGED_DEPTH);
   localparam int MCNT_W = $clog2(MERGED_DEPTH + 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT  = CNT_W'(LIST_DEPTH);
   localparam logic [MCNT_W-1:0] MERGED_FULL = MCNT_W'(MERGED_DEPTH);

   logic [VALUE_W-1:0] first_mem  [LIST_DEPTH];
   logic [VALUE_W-1:0] second_mem [LIST_DEPTH];
   logic [VALUE_W-1:0] merged_mem [MERGED_DEPTH];

   step_type       step_ff, step_in;
   ucode_word_type cw;

   logic [CNT_W-1:0]  first_count_ff, first_count_in;
   logic [CNT_W-1:0]  second_count_ff, second_count_in;
   logic              src_first_ff, src_first_in;
   logic [MCNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [MCNT_W-1:0] k_ff, k_in;
   logic [MCNT_W-1:0] m_ff, m_in;
   logic [VALUE_W-1:0] first_rd_ff, second_rd_ff, merged_rd_ff;

   logic              req_fire, rsp_fire, cond_hit;
   logic              app_first, app_second;
   logic              lists_empty;
   logic [CNT_W-1:0]  src_len, dst_len, max_count;
   logic [MCNT_W-1:0] i_inc;
   logic [IDX_W-1:0]  list_addr;
   logic [VALUE_W-1:0] src_val, dst_val;

   // ---------------------------------------------------------------- control
   assign cw = ucode_rom(step_ff);

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   assign lists_empty = (first_count_ff == '0) && (second_count_ff == '0);
   assign src_len   = src_first_ff ? first_count_ff : second_count_ff;
   assign dst_len   = src_first_ff ? second_count_ff : first_count_ff;
   assign max_count = (first_count_ff <= second_count_ff) ? second_count_ff : first_count_ff;
   assign i_inc     = i_ff + MCNT_W'(1);
   assign src_val   = src_first_ff ? first_rd_ff : second_rd_ff;
   assign dst_val   = src_first_ff ? second_rd_ff : first_rd_ff;

   // next step
   always_comb begin
      case (cw.cond)
         C_ALWAYS:     cond_hit = 1'b1;
         C_MERGE:      cond_hit = req_fire && (op_type'(req_operation) == OP_MERGE);
         C_BOTH_EMPTY: cond_hit = lists_empty;
         C_CP_END:     cond_hit = (i_inc == MCNT_W'(dst_len));
         C_J_END:      cond_hit = (j_ff == src_len);
         C_K_END:      cond_hit = (k_ff == m_ff);
         C_MATCH:      cond_hit = (merged_rd_ff == src_val);
         C_RSP_ACC:    cond_hit = rsp_fire;
         C_OUT_END:    cond_hit = (i_inc == m_ff);
         default:      cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? cw.next_t : cw.next_f;
   end

   // port outputs
   always_comb begin
      req_stall     = !cw.in_ready;
      rsp_valid     = cw.out_valid;
      rsp_empty_res = cw.out_empty;
      rsp_last      = cw.out_empty || (i_inc == m_ff);
      rsp_element   = cw.out_empty ? '0 : $signed(merged_rd_ff);
   end

   // ---------------------------------------------------------------- datapath
   assign app_first  = req_fire && (op_type'(req_operation) == OP_APPEND_FIRST)
                       && (first_count_ff < CNT_W'(LIST_DEPTH));
   assign app_second = req_fire && (op_type'(req_operation) == OP_APPEND_SECOND)
                       && (second_count_ff < CNT_W'(LIST_DEPTH));

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      if (cw.clr_counts) begin
         first_count_in  = '0;
         second_count_in = '0;
      end else begin
         if (app_first)  first_count_in  = first_count_ff + CNT_W'(1);
         if (app_second) second_count_in = second_count_ff + CNT_W'(1);
      end

      src_first_in = cw.pick_src ? (first_count_ff <= second_count_ff) : src_first_ff;

      case (cw.i_op)
         IX_ZERO: i_in = '0;
         IX_INC:  i_in = i_inc;
         default: i_in = i_ff;
      endcase
      case (cw.j_op)
         IX_ZERO: j_in = '0;
         IX_INC:  j_in = j_ff + CNT_W'(1);
         default: j_in = j_ff;
      endcase
      case (cw.k_op)
         IX_ZERO: k_in = '0;
         IX_INC:  k_in = k_ff + MCNT_W'(1);
         default: k_in = k_ff;
      endcase
      case (cw.m_op)
         MX_LOAD: m_in = MCNT_W'(max_count);
         MX_INC:  m_in = m_ff + MCNT_W'(1);
         default: m_in = m_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff         <= S_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
      end else begin
         step_ff         <= step_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
      end
   end

   always_ff @(posedge clock) begin
      src_first_ff <= src_first_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      m_ff         <= m_in;
   end

   // ---------------------------------------------------------------- memories
   assign list_addr = cw.list_rd_src ? j_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (app_first) begin
         first_mem[first_count_ff[IDX_W-1:0]] <= req_value;
      end
      if (cw.list_rd) begin
         first_rd_ff <= first_mem[list_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (app_second) begin
         second_mem[second_count_ff[IDX_W-1:0]] <= req_value;
      end
      if (cw.list_rd) begin
         second_rd_ff <= second_mem[list_addr];
      end
   end

   always_ff @(posedge clock) begin
      case (cw.mwr)
         MWR_COPY:   merged_mem[i_ff[MIDX_W-1:0]] <= dst_val;
         MWR_APPEND: merged_mem[m_ff[MIDX_W-1:0]] <= src_val;
         default: ;
      endcase
      case (cw.mrd)
         MRD_K:   merged_rd_ff <= merged_mem[k_ff[MIDX_W-1:0]];
         MRD_I:   merged_rd_ff <= merged_mem[i_ff[MIDX_W-1:0]];
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- checks
   `LUM_ASSERT_NOW(a_no_req_while_rsp, rsp_valid, req_stall, "request taken while result pending")
   `LUM_ASSERT_NOW(a_first_bound, 1'b1, first_count_ff <= FULL_COUNT, "first count over depth")
   `LUM_ASSERT_NOW(a_second_bound, 1'b1, second_count_ff <= FULL_COUNT, "second count over depth")
   `LUM_ASSERT_NOW(a_append_room, step_ff == S_APPEND, m_ff < MERGED_FULL, "merged list overflow")
   `LUM_ASSERT_NEXT(a_done_clears, step_ff == S_DONE, lists_empty, "lists not cleared after merge")

endmodule
